/* design/bqc_pkg.sv */
// shared types and constants of the cascaded biquad low-cut / high-cut filter
`default_nettype none

package bqc_pkg;

	// extra fraction bits of the delay state beyond a sample
	localparam int EXTRA_FRAC = 8;

	// configuration port
	localparam int CFG_IDX_BITS = 3;
	localparam int CNT_BITS     = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_LOW_SECTIONS  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOW_B0        = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOW_A1        = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOW_A2        = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_SECTIONS = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_B0       = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_A1       = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_A2       = 3'd7;

	// chain select
	localparam logic CHAIN_LOW  = 1'b0;
	localparam logic CHAIN_HIGH = 1'b1;

	// datapath operations
	typedef logic [3:0] op_t;
	localparam op_t OP_NONE     = 4'd0;
	localparam op_t OP_LOAD_X   = 4'd1;
	localparam op_t OP_MUL_B0   = 4'd2;
	localparam op_t OP_ROUND_P  = 4'd3;
	localparam op_t OP_CALC_Y   = 4'd4;
	localparam op_t OP_MUL_A1   = 4'd5;
	localparam op_t OP_CALC_S1  = 4'd6;
	localparam op_t OP_MUL_A2   = 4'd7;
	localparam op_t OP_WRITE    = 4'd8;
	localparam op_t OP_LOAD_OUT = 4'd9;

	typedef struct packed {
		op_t  op;
		logic chain;
	} cmd_t;

	typedef struct packed {
		logic low_empty;
		logic high_empty;
		logic sec_last;
	} stat_t;

endpackage

`default_nettype wire

/* design/bqc_ifs.sv */
// request channels of the cascaded biquad filter
`default_nettype none

interface bqc_in_if #(
	parameter int SAMPLE_BITS = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqc_out_if #(
	parameter int SAMPLE_BITS = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* design/bqc_ctrl.sv */
// sequencer of the cascaded biquad filter: walks sections and drives handshakes
`default_nettype none

module bqc_ctrl #(
	parameter int MAX_SECTIONS = 4,
	localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire bqc_pkg::stat_t status,
	output bqc_pkg::cmd_t       cmd,
	output logic [SW-1:0]       sec
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MB   = 4'd1;
	localparam logic [3:0] ST_PB   = 4'd2;
	localparam logic [3:0] ST_Y    = 4'd3;
	localparam logic [3:0] ST_MA1  = 4'd4;
	localparam logic [3:0] ST_S1   = 4'd5;
	localparam logic [3:0] ST_MA2  = 4'd6;
	localparam logic [3:0] ST_WR   = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	logic [3:0]    state_q, state_d;
	logic          chain_q, chain_d;
	logic [SW-1:0] sec_q, sec_d;
	logic          out_valid_q, out_valid_d;
	logic          accept;
	logic          load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign sec       = sec_q;

	always_comb begin
		state_d     = state_q;
		chain_d     = chain_q;
		sec_d       = sec_q;
		out_valid_d = out_valid_q;
		cmd.chain   = chain_q;
		cmd.op      = bqc_pkg::OP_NONE;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.op = bqc_pkg::OP_LOAD_X;
					sec_d  = '0;
					if (!status.low_empty) begin
						chain_d = bqc_pkg::CHAIN_LOW;
						state_d = ST_MB;
					end else if (!status.high_empty) begin
						chain_d = bqc_pkg::CHAIN_HIGH;
						state_d = ST_MB;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_MB: begin
				cmd.op  = bqc_pkg::OP_MUL_B0;
				state_d = ST_PB;
			end
			ST_PB: begin
				cmd.op  = bqc_pkg::OP_ROUND_P;
				state_d = ST_Y;
			end
			ST_Y: begin
				cmd.op  = bqc_pkg::OP_CALC_Y;
				state_d = ST_MA1;
			end
			ST_MA1: begin
				cmd.op  = bqc_pkg::OP_MUL_A1;
				state_d = ST_S1;
			end
			ST_S1: begin
				cmd.op  = bqc_pkg::OP_CALC_S1;
				state_d = ST_MA2;
			end
			ST_MA2: begin
				cmd.op  = bqc_pkg::OP_MUL_A2;
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.op = bqc_pkg::OP_WRITE;
				if (!status.sec_last) begin
					sec_d   = sec_q + SW'(1);
					state_d = ST_MB;
				end else if (chain_q == bqc_pkg::CHAIN_LOW && !status.high_empty) begin
					chain_d = bqc_pkg::CHAIN_HIGH;
					sec_d   = '0;
					state_d = ST_MB;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (load_out) begin
					cmd.op      = bqc_pkg::OP_LOAD_OUT;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chain_q     <= bqc_pkg::CHAIN_LOW;
			sec_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			chain_q     <= chain_d;
			sec_q       <= sec_d;
			out_valid_q <= out_valid_d;
		end
	end

	// result register is only overwritten once its previous value is gone
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bqc_pkg::OP_LOAD_OUT |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending request");

	// an accepted sample goes straight into a section or to the result stage
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MB || state_q == ST_FIN))
		else $error("bad state after accepting a sample");

	// a chain switch always starts at the first section
	a_chain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MB && chain_q != $past(chain_q)) |-> sec_q == '0)
		else $error("high-cut chain entered past its first section");

	// a section runs its full sequence once started
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MB |=> ##5 state_q == ST_WR)
		else $error("section sequence broken");

endmodule

`default_nettype wire

/* design/bqc_dp.sv */
// datapath of the cascaded biquad filter: coefficients, shared multiplier, delay memory
`default_nettype none

module bqc_dp #(
	parameter int MAX_SECTIONS = 4,
	parameter int SAMPLE_BITS  = 24,
	parameter int COEF_BITS    = 32,
	localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [bqc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire logic [COEF_BITS-1:0]                  cfg_data,
	input  wire bqc_pkg::cmd_t                         cmd,
	input  wire logic [SW-1:0]                         sec,
	input  wire logic signed [SAMPLE_BITS-1:0]         sample_in,
	output bqc_pkg::stat_t                             status,
	output logic signed [SAMPLE_BITS-1:0]              sample_out
);

	localparam int DW = SAMPLE_BITS + 16;                       // delay width
	localparam int MW = COEF_BITS + SAMPLE_BITS;                // product width
	localparam int SH = COEF_BITS - 2 - bqc_pkg::EXTRA_FRAC;    // product shift
	localparam int PW = MW + 1 - SH;                            // rounded product
	localparam int AW = DW + 2;                                 // accumulate width
	localparam int FR = bqc_pkg::EXTRA_FRAC;
	localparam int CW = bqc_pkg::CNT_BITS + 1;

	localparam logic [MW:0]          PR_HALF = {{MW{1'b0}}, 1'b1} << (SH - 1);
	localparam logic signed [AW-1:0] Y_HALF  = {{(AW-1){1'b0}}, 1'b1} << (FR - 1);
	localparam logic [CW-1:0]        MAX_CNT = CW'(MAX_SECTIONS);

	// configuration registers, one set per chain
	logic [bqc_pkg::CNT_BITS-1:0] cnt_q [2];
	logic signed [COEF_BITS-1:0]  b0_q  [2];
	logic signed [COEF_BITS-1:0]  a1_q  [2];
	logic signed [COEF_BITS-1:0]  a2_q  [2];

	// working registers
	logic signed [SAMPLE_BITS-1:0] x_q, y_q, out_q;
	logic signed [MW-1:0]          prod_q;
	logic signed [PW-1:0]          p_q;
	logic signed [DW-1:0]          s1n_q;
	logic [2*DW-1:0]               rd_q;
	logic                          rd_vld_q;

	// delay memory, one row {s1, s2} per section
	logic [2*DW-1:0] mem_q [2][MAX_SECTIONS];
	logic            vld_q [2][MAX_SECTIONS];

	logic                          ch;
	logic signed [COEF_BITS-1:0]   coef_sel;
	logic signed [SAMPLE_BITS-1:0] mul_x;
	logic signed [MW-1:0]          mul_res;
	logic [MW:0]                   pr_sum;
	logic signed [PW-1:0]          pr_rnd;
	logic signed [DW-1:0]          s1_cur, s2_cur;
	logic signed [AW-1:0]          y_sum, tp, s1_sum, s2_sum;
	logic [AW-FR-SAMPLE_BITS:0]    y_hi;
	logic [AW-DW:0]                s1_hi, s2_hi;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic signed [DW-1:0]          s1_sat, s2_sat;
	logic [CW-1:0]                 eff_cnt [2];

	assign ch = cmd.chain;

	// status toward the sequencer
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			eff_cnt[c] = ({1'b0, cnt_q[c]} > MAX_CNT) ? MAX_CNT : {1'b0, cnt_q[c]};
		end
		status.low_empty  = (cnt_q[bqc_pkg::CHAIN_LOW] == '0);
		status.high_empty = (cnt_q[bqc_pkg::CHAIN_HIGH] == '0);
		status.sec_last   = ((CW'(sec) + CW'(1)) == eff_cnt[ch]);
	end

	// shared multiplier operands
	always_comb begin
		case (cmd.op)
			bqc_pkg::OP_MUL_A1: coef_sel = a1_q[ch];
			bqc_pkg::OP_MUL_A2: coef_sel = a2_q[ch];
			default:            coef_sel = b0_q[ch];
		endcase
		mul_x = (cmd.op == bqc_pkg::OP_MUL_B0) ? x_q : y_q;
	end
	assign mul_res = coef_sel * mul_x;

	// round half up of the product
	assign pr_sum = {prod_q[MW-1], prod_q} + PR_HALF;
	assign pr_rnd = $signed(pr_sum[MW:SH]);

	// unwritten rows read as zero
	assign s1_cur = rd_vld_q ? $signed(rd_q[2*DW-1:DW]) : '0;
	assign s2_cur = rd_vld_q ? $signed(rd_q[DW-1:0]) : '0;

	// section output
	assign y_sum = AW'(p_q) + AW'(s1_cur) + Y_HALF;
	assign y_hi  = y_sum[AW-1:FR+SAMPLE_BITS-1];
	assign y_sat = (&y_hi || !(|y_hi)) ? $signed(y_sum[FR+SAMPLE_BITS-1:FR])
		: $signed({y_sum[AW-1], {(SAMPLE_BITS-1){~y_sum[AW-1]}}});

	// next delay values
	assign tp     = AW'(p_q) <<< 1;
	assign s1_sum = ((ch == bqc_pkg::CHAIN_LOW) ? -tp : tp) - AW'(pr_rnd) + AW'(s2_cur);
	assign s1_hi  = s1_sum[AW-1:DW-1];
	assign s1_sat = (&s1_hi || !(|s1_hi)) ? $signed(s1_sum[DW-1:0])
		: $signed({s1_sum[AW-1], {(DW-1){~s1_sum[AW-1]}}});
	assign s2_sum = AW'(p_q) - AW'(pr_rnd);
	assign s2_hi  = s2_sum[AW-1:DW-1];
	assign s2_sat = (&s2_hi || !(|s2_hi)) ? $signed(s2_sum[DW-1:0])
		: $signed({s2_sum[AW-1], {(DW-1){~s2_sum[AW-1]}}});

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				cnt_q[c] <= '0;
				b0_q[c]  <= '0;
				a1_q[c]  <= '0;
				a2_q[c]  <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				bqc_pkg::REG_LOW_SECTIONS:  cnt_q[bqc_pkg::CHAIN_LOW]  <= cfg_data[bqc_pkg::CNT_BITS-1:0];
				bqc_pkg::REG_LOW_B0:        b0_q[bqc_pkg::CHAIN_LOW]   <= cfg_data;
				bqc_pkg::REG_LOW_A1:        a1_q[bqc_pkg::CHAIN_LOW]   <= cfg_data;
				bqc_pkg::REG_LOW_A2:        a2_q[bqc_pkg::CHAIN_LOW]   <= cfg_data;
				bqc_pkg::REG_HIGH_SECTIONS: cnt_q[bqc_pkg::CHAIN_HIGH] <= cfg_data[bqc_pkg::CNT_BITS-1:0];
				bqc_pkg::REG_HIGH_B0:       b0_q[bqc_pkg::CHAIN_HIGH]  <= cfg_data;
				bqc_pkg::REG_HIGH_A1:       a1_q[bqc_pkg::CHAIN_HIGH]  <= cfg_data;
				bqc_pkg::REG_HIGH_A2:       a2_q[bqc_pkg::CHAIN_HIGH]  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				for (int k = 0; k < MAX_SECTIONS; k++) begin
					vld_q[c][k] <= 1'b0;
				end
			end
		end else if (cmd.op == bqc_pkg::OP_WRITE) begin
			vld_q[ch][sec] <= 1'b1;
		end
	end

	// delay memory: registered read at section start, write at section end
	always_ff @(posedge clk) begin
		if (cmd.op == bqc_pkg::OP_MUL_B0) begin
			rd_q     <= mem_q[ch][sec];
			rd_vld_q <= vld_q[ch][sec];
		end
		if (cmd.op == bqc_pkg::OP_WRITE) begin
			mem_q[ch][sec] <= {s1n_q, s2_sat};
		end
	end

	// arithmetic steps
	always_ff @(posedge clk) begin
		case (cmd.op)
			bqc_pkg::OP_LOAD_X:   x_q    <= sample_in;
			bqc_pkg::OP_MUL_B0:   prod_q <= mul_res;
			bqc_pkg::OP_ROUND_P:  p_q    <= pr_rnd;
			bqc_pkg::OP_CALC_Y:   y_q    <= y_sat;
			bqc_pkg::OP_MUL_A1:   prod_q <= mul_res;
			bqc_pkg::OP_CALC_S1:  s1n_q  <= s1_sat;
			bqc_pkg::OP_MUL_A2:   prod_q <= mul_res;
			bqc_pkg::OP_WRITE:    x_q    <= y_q;
			bqc_pkg::OP_LOAD_OUT: out_q  <= x_q;
			default: begin
			end
		endcase
	end

	assign sample_out = out_q;

endmodule

`default_nettype wire

/* design/biquad_low_high_cut_cascade.sv */
// top level of the cascaded low-cut / high-cut biquad filter
`default_nettype none

// Audio filter: each request on the sample channel passes through a low-cut chain and then a
// high-cut chain of transposed direct form II biquads (0 to MAX_SECTIONS sections each, a
// count of zero bypasses the chain); every section keeps its own two delay values across
// samples and rounds and saturates its output to SAMPLE_BITS. Coefficients are Q2.30 b0, a1,
// a2 per chain with b2 = b0 and b1 = -2*b0 (low cut) or +2*b0 (high cut), written through the
// plain register port; the user must write them only while the block is idle, which the block
// itself does not enforce. The single shared multiplier forms b0*x, a1*y and a2*y of each
// section in turn, and the one-port delay memory is read at section start and written at
// section end. A new sample is taken while the previous result still waits in the output
// register.
module biquad_low_high_cut_cascade #(
	parameter int MAX_SECTIONS = 4,
	parameter int SAMPLE_BITS  = 24,
	parameter int COEF_BITS    = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	bqc_in_if.sink                                samples,
	bqc_out_if.source                             filtered,
	input  wire logic                             cfg_we,
	input  wire logic [bqc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [COEF_BITS-1:0]             cfg_data
);

	localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

	// command and status between sequencer and datapath
	bqc_pkg::cmd_t  cmd;
	bqc_pkg::stat_t status;
	logic [SW-1:0]  sec;

	// sequencer: accepts a request, walks low-cut then high-cut sections, loads the result
	bqc_ctrl #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.out_valid(filtered.valid),
		.out_ready(filtered.ready),
		.status   (status),
		.cmd      (cmd),
		.sec      (sec)
	);

	// datapath: coefficient registers, shared multiplier, per-section delay memory
	bqc_dp #(
		.MAX_SECTIONS(MAX_SECTIONS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sec       (sec),
		.sample_in (samples.sample_in),
		.status    (status),
		.sample_out(filtered.sample_out)
	);

endmodule

`default_nettype wire
